[hdl/efdu_pkg.sv]
// Shared types and constants for the extended-to-double converter.
// Used by extended_float_to_double_and_uint and efdu_uint_conv; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efdu_pkg;

   localparam logic [14:0] EXT_EXP_MAX = 15'h7FFF;
   localparam logic [14:0] EXT_BIAS    = 15'h3FFF;
   localparam logic [10:0] DBL_BIAS    = 11'h3FF;
   localparam logic [10:0] DBL_EXP_MAX = 11'h7FF;

   // Rebias offset: extended exponent minus this gives the double exponent.
   localparam logic [14:0] REBIAS      = EXT_BIAS - 15'(DBL_BIAS);
   // Largest extended exponent that still underflows to zero (R == -52).
   localparam logic [14:0] EXP_UNDER   = REBIAS - 15'd52;
   // First extended exponent that overflows to infinity (R == 2047).
   localparam logic [14:0] EXP_OVER    = REBIAS + 15'(DBL_EXP_MAX);
   // Subnormal shift is 12 - R, i.e. SUB_SHIFT_BASE - E.
   localparam logic [14:0] SUB_SHIFT_BASE = REBIAS + 15'd12;

   // Double exponent window for the integer part: bias .. bias + 31.
   localparam logic [10:0] INT_EXP_TOP = DBL_BIAS + 11'd32;
   // Integer shift is 52 - k, i.e. INT_SHIFT_BASE - exponent.
   localparam logic [10:0] INT_SHIFT_BASE = DBL_BIAS + 11'd52;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_CLAMP = 2'd1,
      STAT_NEG   = 2'd2
   } int_status_type;

   typedef enum logic [2:0] {
      CLS_ZERO,
      CLS_SPECIAL,
      CLS_OVER,
      CLS_SUB,
      CLS_NORM
   } num_class_type;

   typedef struct packed {
      logic          sign;
      num_class_type cls;
      logic [10:0]   exponent;
      logic [5:0]    sub_shift;
      logic [63:0]   mantissa;
   } decode_type;

endpackage

`default_nettype wire

[hdl/extended_float_to_double_and_uint.sv]
// Three-stage pipelined 80-bit extended to double and uint32 converter.
// Depends on efdu_pkg and efdu_uint_conv.
//
// Usage:
//   The req_ channel carries one extended value per word: the sign/exponent
//   word and the 64-bit mantissa with its explicit integer bit. The rsp_
//   channel returns, per word, the double bit pattern (mantissa truncated),
//   the value truncated toward zero as an unsigned 32-bit integer, and a
//   status code (in range, clamped high, or negative/NaN forced to zero).
//   A word is registered by the decode, shift and integer stages in turn
//   before it shows rsp_tvalid and can be taken by the receiver. The
//   stages are decode and classify, subnormal shift and packing, and integer
//   extraction. One word is accepted every cycle while the receiver takes
//   results, since each stage passes its word on at every edge.
//   When the receiver stalls, each stage holds its word and fills any empty
//   stage ahead of it; req_tready falls only once the first stage is full
//   and cannot move. Nothing is dropped or repeated.
//   Reset empties all stages; no words are shown until new ones arrive.
`timescale 1ns / 1ps
`default_nettype none

module extended_float_to_double_and_uint (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [15:0] ext_sign_exponent, [79:16] ext_mantissa
   input  wire logic [79:0]   req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [63:0] double_bits, [95:64] int_value, [97:96] int_status, [103:98] zero
   output logic [103:0]       rsp_tdata
);
   import efdu_pkg::*;

   logic           s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic           adv1, adv2, adv3;

   decode_type     s1_in, s1_ff;
   logic [63:0]    s2_in, s2_ff;
   logic [31:0]    int_value_in, int_value_ff;
   int_status_type int_status_in, int_status_ff;
   logic [63:0]    s3_double_ff;

   logic [15:0]    in_se;
   logic [63:0]    in_man;
   logic [14:0]    in_exp;
   logic [14:0]    shift_full;

   // Each stage moves when it is empty or the stage after it moves.
   assign adv3       = !s3_valid_ff || rsp_tready;
   assign adv2       = !s2_valid_ff || adv3;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_tready = adv1;

   // Stage 1: classify the exponent.
   assign in_se      = req_tdata[15:0];
   assign in_man     = req_tdata[79:16];
   assign in_exp     = in_se[14:0];
   assign shift_full = SUB_SHIFT_BASE - in_exp;

   always_comb begin
      s1_in.sign      = in_se[15];
      s1_in.mantissa  = in_man;
      s1_in.sub_shift = shift_full[5:0];
      s1_in.exponent  = 11'(in_exp - REBIAS);
      if (in_exp == '0 || in_exp <= EXP_UNDER) begin
         s1_in.cls = CLS_ZERO;
      end else if (in_exp == EXT_EXP_MAX) begin
         s1_in.cls = CLS_SPECIAL;
      end else if (in_exp >= EXP_OVER) begin
         s1_in.cls = CLS_OVER;
      end else if (in_exp <= REBIAS) begin
         s1_in.cls = CLS_SUB;
      end else begin
         s1_in.cls = CLS_NORM;
      end
   end

   // Stage 2: build the double pattern.
   always_comb begin
      case (s1_ff.cls)
         CLS_ZERO:    s2_in = {s1_ff.sign, 63'd0};
         CLS_SPECIAL: s2_in = {s1_ff.sign, DBL_EXP_MAX, s1_ff.mantissa[62:11]};
         CLS_OVER:    s2_in = {s1_ff.sign, DBL_EXP_MAX, 52'd0};
         CLS_SUB:     s2_in = {s1_ff.sign, 11'd0,
                               52'(s1_ff.mantissa >> s1_ff.sub_shift)};
         CLS_NORM:    s2_in = {s1_ff.sign, s1_ff.exponent, s1_ff.mantissa[62:11]};
         default:     s2_in = {s1_ff.sign, 63'd0};
      endcase
   end

   // Stage 3: integer part from the truncated double.
   efdu_uint_conv u_uint (
      .double_bits (s2_ff),
      .int_value   (int_value_in),
      .int_status  (int_status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= s1_in;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
      if (adv3) begin
         s3_double_ff  <= s2_ff;
         int_value_ff  <= int_value_in;
         int_status_ff <= int_status_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {6'd0, int_status_ff, int_value_ff, s3_double_ff};

   a_clamp_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && int_status_ff == STAT_CLAMP |-> int_value_ff == 32'hFFFF_FFFF)
      else $error("clamped result is not all ones");

   a_neg_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && int_status_ff == STAT_NEG |-> int_value_ff == '0)
      else $error("negative or NaN result is not zero");

   a_zero_exp_class: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[14:0] == '0 |=> s1_ff.cls == CLS_ZERO)
      else $error("zero exponent not classified as zero");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && !rsp_tready)
      else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire

[hdl/efdu_uint_conv.sv]
// Truncating double-to-unsigned-32 conversion with saturation and status.
// Combinational; depends on efdu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efdu_uint_conv (
   input  wire logic [63:0]             double_bits,
   output logic [31:0]                  int_value,
   output efdu_pkg::int_status_type     int_status
);
   import efdu_pkg::*;

   logic        neg;
   logic [10:0] ex;
   logic [51:0] frac;
   logic [10:0] shift_full;
   logic [52:0] shifted;

   assign neg  = double_bits[63];
   assign ex   = double_bits[62:52];
   assign frac = double_bits[51:0];

   // Valid only inside the in-range window, where it lies in 21..52.
   assign shift_full = INT_SHIFT_BASE - ex;
   assign shifted    = {1'b1, frac} >> shift_full[5:0];

   always_comb begin
      int_value  = '0;
      int_status = STAT_OK;
      if (ex == DBL_EXP_MAX && frac != '0) begin
         int_status = STAT_NEG;
      end else if (ex == '0 && frac == '0) begin
         int_status = STAT_OK;
      end else if (neg) begin
         int_status = STAT_NEG;
      end else if (ex < DBL_BIAS) begin
         int_status = STAT_OK;
      end else if (ex >= INT_EXP_TOP) begin
         int_value  = '1;
         int_status = STAT_CLAMP;
      end else begin
         int_value  = shifted[31:0];
      end
   end

endmodule

`default_nettype wire
